// ===== sv/multi_voice_stereo_pan_mixer_defines.svh =====
// assertion macros for the stereo pan mixer
// no dependencies; taken in by the files that carry assertions
`ifndef MULTI_VOICE_STEREO_PAN_MIXER_DEFINES_SVH
`define MULTI_VOICE_STEREO_PAN_MIXER_DEFINES_SVH

// same-cycle implication
`define MVSPM_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mixer assertion failed");

// next-cycle implication
`define MVSPM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mixer assertion failed");

`endif

// ===== sv/mvspm_pkg.sv =====
// shared constants, codes and transaction types of the stereo pan mixer
// no dependencies
package mvspm_pkg;

   localparam int VOICES          = 8;
   localparam int LENGTH_BITS     = 24;
   localparam int VOICE_IDX_BITS  = (VOICES > 1) ? $clog2(VOICES) : 1;
   localparam int ACC_BITS        = 40;
   localparam int CSR_ADDR_BITS   = 3;
   localparam int CSR_DATA_BITS   = 32;

   localparam logic REG_MASTER_GAIN = 1'b0;
   localparam logic [15:0] MASTER_GAIN_RESET = 16'd16384;

   localparam logic [1:0] OP_START      = 2'd0;
   localparam logic [1:0] OP_MIX        = 2'd1;
   localparam logic [1:0] OP_END_BUFFER = 2'd2;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_NO_FREE = 2'd1;
   localparam logic [1:0] ST_IDLE    = 2'd2;

   typedef struct packed {
      logic [1:0]         opcode;
      logic [2:0]         voice;
      logic signed [15:0] sample_value;
      logic               last_voice;
      logic [23:0]        sample_length;
      logic [15:0]        lgain;
      logic [15:0]        rgain;
      logic               repeat_flag;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [2:0]         voice_out;
      logic [23:0]        fetch_position;
      logic               frame_valid;
      logic signed [15:0] left_out;
      logic signed [15:0] right_out;
   } rsp_type;

   typedef struct packed {
      logic [LENGTH_BITS-1:0] length;
      logic [LENGTH_BITS-1:0] position;
      logic [15:0]            lgain;
      logic [15:0]            rgain;
      logic                   repeats;
   } voice_entry_type;

endpackage

// ===== sv/mvspm_ram.sv =====
// generic simple dual-port ram, one write and one registered read per cycle
// no dependencies
module mvspm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/multi_voice_stereo_pan_mixer.sv =====
// top level of the stereo pan mixer: voice table in ram, gain pipeline, accumulators
// depends on mvspm_pkg, mvspm_ram and multi_voice_stereo_pan_mixer_defines.svh
//
//   channel   handshake                        payload
//   request   start, busy                      req_item (req_type)
//   result    rsp_valid strobe, one cycle      rsp_item (rsp_type)
//   config    psel/penable/pwrite, pready=1    paddr, pwdata, prdata
//
// start item: result strobe in the next cycle
// mix item: voice ram read, gain multiply, master multiply, accumulate
// end-of-buffer item: one voice table entry a cycle through the ram
// reset is synchronous; it empties the voice table and clears the accumulators
// results are never stalled; busy is high while a mix or sweep is under way
`include "multi_voice_stereo_pan_mixer_defines.svh"

module multi_voice_stereo_pan_mixer
   import mvspm_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  req_type                  req_item,
   output logic                     rsp_valid,
   output rsp_type                  rsp_item,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready
);

   localparam logic [VOICE_IDX_BITS-1:0] IDX_LAST = VOICE_IDX_BITS'(VOICES - 1);
   localparam logic signed [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
   localparam logic signed [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};

   typedef enum logic [2:0] {S_IDLE, S_EVAL, S_SCALE, S_ACC, S_SWEEP} state_type;

   state_type               state_ff, state_in;
   logic [VOICES-1:0]       active_ff, active_in;
   logic [15:0]             master_ff, master_in;
   logic signed [ACC_BITS-1:0] sum_l_ff, sum_l_in, sum_r_ff, sum_r_in;
   req_type                 item_ff, item_in;
   logic [VOICE_IDX_BITS-1:0] idx_ff, idx_in, cnt_ff, cnt_in;
   logic                    live_ff, live_in;
   logic [23:0]             fetch_ff, fetch_in;
   logic signed [32:0]      prod_l_ff, prod_l_in, prod_r_ff, prod_r_in;
   logic signed [35:0]      scal_l_ff, scal_l_in, scal_r_ff, scal_r_in;
   rsp_type                 rsp_ff, rsp_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   logic                    accept;
   logic                    free_found;
   logic [VOICE_IDX_BITS-1:0] free_idx;
   logic                    wr_en, rd_en;
   logic [VOICE_IDX_BITS-1:0] wr_addr, rd_addr;
   voice_entry_type         wr_data, entry;
   logic [$bits(voice_entry_type)-1:0] rd_bits;
   logic [LENGTH_BITS-1:0]  pos_next;
   logic [LENGTH_BITS+23:0] fetch_wide;
   logic [LENGTH_BITS+23:0] len_wide;
   logic                    in_range;
   logic                    live;
   logic signed [21:0]      add_l, add_r;
   logic signed [ACC_BITS-1:0] new_l, new_r;
   logic                    cfg_write;

   function automatic logic signed [ACC_BITS-1:0] acc_add(
      input logic signed [ACC_BITS-1:0] acc,
      input logic signed [21:0]         v
   );
      logic signed [ACC_BITS:0] r;
      r = (ACC_BITS+1)'(acc) + (ACC_BITS+1)'(v);
      if (r[ACC_BITS] != r[ACC_BITS-1]) begin
         return r[ACC_BITS] ? ACC_MIN : ACC_MAX;
      end
      return r[ACC_BITS-1:0];
   endfunction

   function automatic logic signed [15:0] sat16(input logic signed [ACC_BITS-1:0] v);
      if (v > 40'sd32767) begin
         return 16'sh7fff;
      end else if (v < -40'sd32768) begin
         return 16'sh8000;
      end
      return v[15:0];
   endfunction

   mvspm_ram #(
      .WIDTH ($bits(voice_entry_type)),
      .DEPTH (VOICES)
   ) u_voice_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_bits)
   );

   assign entry     = voice_entry_type'(rd_bits);
   assign busy      = (state_ff != S_IDLE);
   assign accept    = start && !busy;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite;
   assign prdata    = (paddr[2] == REG_MASTER_GAIN) ? {16'd0, master_ff} : '0;

   // lowest-numbered free voice
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = VOICES - 1; i >= 0; i--) begin
         if (!active_ff[i]) begin
            free_found = 1'b1;
            free_idx   = VOICE_IDX_BITS'(i);
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      active_in    = active_ff;
      master_in    = master_ff;
      sum_l_in     = sum_l_ff;
      sum_r_in     = sum_r_ff;
      item_in      = item_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      live_in      = live_ff;
      fetch_in     = fetch_ff;
      prod_l_in    = prod_l_ff;
      prod_r_in    = prod_r_ff;
      scal_l_in    = scal_l_ff;
      scal_r_in    = scal_r_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = '0;
      rd_en        = 1'b0;
      rd_addr      = '0;
      in_range     = (32'(item_ff.voice) < VOICES);
      live         = 1'b0;
      pos_next     = entry.position + 1'b1;
      fetch_wide   = '0;
      len_wide     = {{LENGTH_BITS{1'b0}}, req_item.sample_length};
      add_l        = $signed(scal_l_ff[35:14]);
      add_r        = $signed(scal_r_ff[35:14]);
      new_l        = sum_l_ff;
      new_r        = sum_r_ff;

      if (cfg_write && paddr[2] == REG_MASTER_GAIN) begin
         master_in = pwdata[15:0];
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               item_in = req_item;
               idx_in  = VOICE_IDX_BITS'(req_item.voice);
               rsp_in  = '0;
               case (req_item.opcode)
                  OP_START: begin
                     rsp_valid_in = 1'b1;
                     if (free_found) begin
                        wr_en               = 1'b1;
                        wr_addr             = free_idx;
                        wr_data.length      = len_wide[LENGTH_BITS-1:0];
                        wr_data.position    = '0;
                        wr_data.lgain       = req_item.lgain;
                        wr_data.rgain       = req_item.rgain;
                        wr_data.repeats     = req_item.repeat_flag;
                        active_in[free_idx] = 1'b1;
                        rsp_in.status       = ST_OK;
                        rsp_in.voice_out    = 3'(free_idx);
                     end else begin
                        rsp_in.status = ST_NO_FREE;
                     end
                  end
                  OP_MIX: begin
                     rd_en    = 1'b1;
                     rd_addr  = VOICE_IDX_BITS'(req_item.voice);
                     state_in = S_EVAL;
                  end
                  OP_END_BUFFER: begin
                     rd_en    = 1'b1;
                     rd_addr  = '0;
                     cnt_in   = '0;
                     state_in = S_SWEEP;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         S_EVAL: begin
            live      = in_range && active_ff[idx_ff] && (entry.position < entry.length);
            live_in   = live;
            prod_l_in = item_ff.sample_value * $signed({1'b0, entry.lgain});
            prod_r_in = item_ff.sample_value * $signed({1'b0, entry.rgain});
            if (live) begin
               wr_en          = 1'b1;
               wr_addr        = idx_ff;
               wr_data        = entry;
               wr_data.position = pos_next;
               fetch_wide     = {24'd0, pos_next};
            end else if (in_range && active_ff[idx_ff]) begin
               fetch_wide     = {24'd0, entry.position};
            end
            fetch_in = fetch_wide[23:0];
            state_in = S_SCALE;
         end
         S_SCALE: begin
            scal_l_in = $signed(prod_l_ff[32:14]) * $signed({1'b0, master_ff});
            scal_r_in = $signed(prod_r_ff[32:14]) * $signed({1'b0, master_ff});
            state_in  = S_ACC;
         end
         S_ACC: begin
            if (live_ff) begin
               new_l = acc_add(sum_l_ff, add_l);
               new_r = acc_add(sum_r_ff, add_r);
            end
            rsp_in.status         = live_ff ? ST_OK : ST_IDLE;
            rsp_in.voice_out      = item_ff.voice;
            rsp_in.fetch_position = fetch_ff;
            if (item_ff.last_voice) begin
               rsp_in.frame_valid = 1'b1;
               rsp_in.left_out    = sat16(new_l);
               rsp_in.right_out   = sat16(new_r);
               sum_l_in           = '0;
               sum_r_in           = '0;
            end else begin
               sum_l_in = new_l;
               sum_r_in = new_r;
            end
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         S_SWEEP: begin
            if (active_ff[cnt_ff] && entry.position >= entry.length) begin
               if (entry.repeats) begin
                  wr_en            = 1'b1;
                  wr_addr          = cnt_ff;
                  wr_data          = entry;
                  wr_data.position = '0;
               end else begin
                  active_in[cnt_ff] = 1'b0;
               end
            end
            if (cnt_ff == IDX_LAST) begin
               rsp_in       = '0;
               rsp_valid_in = 1'b1;
               sum_l_in     = '0;
               sum_r_in     = '0;
               state_in     = S_IDLE;
            end else begin
               rd_en   = 1'b1;
               rd_addr = cnt_ff + 1'b1;
               cnt_in  = cnt_ff + 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         active_ff    <= '0;
         master_ff    <= MASTER_GAIN_RESET;
         sum_l_ff     <= '0;
         sum_r_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         master_ff    <= master_in;
         sum_l_ff     <= sum_l_in;
         sum_r_ff     <= sum_r_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
      item_ff   <= item_in;
      idx_ff    <= idx_in;
      live_ff   <= live_in;
      fetch_ff  <= fetch_in;
      prod_l_ff <= prod_l_in;
      prod_r_ff <= prod_r_in;
      scal_l_ff <= scal_l_in;
      scal_r_ff <= scal_r_in;
      rsp_ff    <= rsp_in;
   end

   `MVSPM_ASSERT_NOW(a_no_frame_zero, clock, reset,
      rsp_valid && !rsp_item.frame_valid,
      rsp_item.left_out == 16'sd0 && rsp_item.right_out == 16'sd0)
   `MVSPM_ASSERT_NEXT(a_accept_progress, clock, reset, accept, busy || rsp_valid)
   `MVSPM_ASSERT_NEXT(a_start_claims, clock, reset,
      accept && req_item.opcode == OP_START && free_found,
      active_ff[$past(free_idx)])
   `MVSPM_ASSERT_NEXT(a_mix_advances, clock, reset,
      state_ff == S_ACC && live_ff, rsp_item.fetch_position != 24'd0)

endmodule
